FILE: src/pwdh_pkg.sv
// pwdh_pkg: shared types, constants and the angle table of the pixel to world block
// no dependencies
`default_nettype none
package pwdh_pkg;

	localparam int FRAC_BITS     = 16;
	localparam int ANG_FRAC      = 24;
	localparam int CORDIC_STAGES = 24;
	localparam int SQRT_STAGES   = 32;
	localparam int QUOT_W        = 48;
	localparam int VEC_W         = 34;
	localparam int ANG_W         = 33;
	localparam int NUM_W         = 82;
	localparam int DEN_W         = 50;
	localparam int LATENCY       = CORDIC_STAGES + SQRT_STAGES + QUOT_W + 9;

	localparam logic [ANG_W-1:0] DEG90 = ANG_W'(64'd90 << ANG_FRAC);

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_CFG = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;
	localparam logic [1:0] ST_SAT     = 2'd3;

	localparam logic [2:0] REG_FOCAL  = 3'd0;
	localparam logic [2:0] REG_DIST   = 3'd1;
	localparam logic [2:0] REG_TILT   = 3'd2;
	localparam logic [2:0] REG_WIDTH  = 3'd3;
	localparam logic [2:0] REG_HEIGHT = 3'd4;

	localparam logic [31:0] ATAN_TAB [32] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
		32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
		32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
		32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229,
		32'd115, 32'd57, 32'd29, 32'd14, 32'd7, 32'd4, 32'd2, 32'd1, 32'd0
	};

	typedef struct packed {
		logic [15:0] pixel_col;
		logic [15:0] pixel_row;
	} pixel_t;

	typedef struct packed {
		logic signed [47:0] height_out;
		logic signed [47:0] depth_out;
		logic [1:0]         status;
	} result_t;

	typedef struct packed {
		logic                    valid;
		logic [1:0]              err;
		logic                    neg_h;
		logic [15:0]             hd;
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] ang;
	} cordic_t;

	typedef struct packed {
		logic [1:0]       err;
		logic             neg_h;
		logic [15:0]      hd;
		logic             neg_d;
		logic             zero_d;
		logic [NUM_W-1:0] n_d;
		logic [DEN_W-1:0] den_d;
		logic [DEN_W-1:0] den_h;
	} side_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] v;
		logic [63:0] res;
		side_t       side;
	} root_t;

	typedef struct packed {
		logic              valid;
		logic [1:0]        err;
		logic              neg;
		logic              zero;
		logic              ovf;
		logic [NUM_W-1:0]  n;
		logic [DEN_W-1:0]  den;
		logic [DEN_W-1:0]  r;
		logic [QUOT_W-1:0] q;
	} quot_t;

	function automatic logic signed [ANG_W-1:0] atan_deg(input logic [4:0] idx);
		atan_deg = ANG_W'(ATAN_TAB[idx]);
	endfunction

endpackage
`default_nettype wire

FILE: src/pwdh_cordic_cell.sv
// pwdh_cordic_cell: one registered cordic rotation step
// depends on pwdh_pkg
`default_nettype none
module pwdh_cordic_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [4:0]        step,
	input  pwdh_pkg::cordic_t din,
	output pwdh_pkg::cordic_t dout
);
	logic signed [pwdh_pkg::VEC_W-1:0] dx;
	logic signed [pwdh_pkg::VEC_W-1:0] dy;
	logic signed [pwdh_pkg::ANG_W-1:0] da;
	pwdh_pkg::cordic_t                 nxt;
	pwdh_pkg::cordic_t                 stage_q;

	always_comb begin
		dx  = din.y >>> step;
		dy  = din.x >>> step;
		da  = pwdh_pkg::atan_deg(step);
		nxt = din;
		if (!din.ang[pwdh_pkg::ANG_W-1]) begin
			nxt.x   = din.x - dx;
			nxt.y   = din.y + dy;
			nxt.ang = din.ang - da;
		end else begin
			nxt.x   = din.x + dx;
			nxt.y   = din.y - dy;
			nxt.ang = din.ang + da;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
		end else begin
			stage_q <= nxt;
		end
	end

	assign dout = stage_q;
endmodule
`default_nettype wire

FILE: src/pwdh_sqrt_cell.sv
// pwdh_sqrt_cell: one registered step of the integer square root, two radicand bits
// depends on pwdh_pkg
`default_nettype none
module pwdh_sqrt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [4:0]      step,
	input  pwdh_pkg::root_t din,
	output pwdh_pkg::root_t dout
);
	logic [5:0]      sh;
	logic [63:0]     one_bit;
	logic [63:0]     trial;
	pwdh_pkg::root_t nxt;
	pwdh_pkg::root_t stage_q;

	always_comb begin
		sh      = 6'd62 - {step, 1'b0};
		one_bit = 64'(1) << sh;
		trial   = din.res + one_bit;
		nxt     = din;
		if (din.v >= trial) begin
			nxt.v   = din.v - trial;
			nxt.res = (din.res >> 1) + one_bit;
		end else begin
			nxt.res = din.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
		end else begin
			stage_q <= nxt;
		end
	end

	assign dout = stage_q;
endmodule
`default_nettype wire

FILE: src/pwdh_div_cell.sv
// pwdh_div_cell: one registered restoring division step, one quotient bit
// depends on pwdh_pkg
`default_nettype none
module pwdh_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [5:0]      step,
	input  pwdh_pkg::quot_t din,
	output pwdh_pkg::quot_t dout
);
	logic [5:0]                idx;
	logic [pwdh_pkg::DEN_W:0]  r2;
	logic [pwdh_pkg::QUOT_W-1:0] low_n;
	pwdh_pkg::quot_t           nxt;
	pwdh_pkg::quot_t           stage_q;

	always_comb begin
		idx   = 6'(pwdh_pkg::QUOT_W - 1) - step;
		low_n = din.n[pwdh_pkg::QUOT_W-1:0];
		r2    = {din.r, low_n[idx]};
		nxt   = din;
		if (r2 >= {1'b0, din.den}) begin
			nxt.r      = pwdh_pkg::DEN_W'(r2 - {1'b0, din.den});
			nxt.q[idx] = 1'b1;
		end else begin
			nxt.r = pwdh_pkg::DEN_W'(r2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
		end else begin
			stage_q <= nxt;
		end
	end

	assign dout = stage_q;
endmodule
`default_nettype wire

FILE: src/pixel_to_world_depth_height_top.sv
// pixel_to_world_depth_height_top: configuration registers, cordic, root and divider chains
// depends on pwdh_pkg, pwdh_cordic_cell, pwdh_sqrt_cell, pwdh_div_cell
`default_nettype none
// One pixel word may be started every clock; busy never rises. Each result
// appears on result for one cycle with done, in start order, and cannot be
// held off. The pipeline is made of the chains and registers: 24 cordic cells,
// 32 square root cells, 48 divider cells (one quotient bit each, depth and
// height in parallel) and 9 setup and output registers.
// Configuration writes are taken at once and must only happen while no pixel
// is in flight.
module pixel_to_world_depth_height_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pwdh_pkg::pixel_t  pixel,
	output logic              done,
	output pwdh_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	localparam int VW = pwdh_pkg::VEC_W;
	localparam int AW = pwdh_pkg::ANG_W;
	localparam int NW = pwdh_pkg::NUM_W;
	localparam int DW = pwdh_pkg::DEN_W;
	localparam int QW = pwdh_pkg::QUOT_W;

	logic [15:0] focal_q;
	logic [31:0] dist_q;
	logic [22:0] tilt_q;
	logic [15:0] width_q;
	logic [15:0] height_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q  <= '0;
			dist_q   <= '0;
			tilt_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				pwdh_pkg::REG_FOCAL:  focal_q  <= cfg_data[15:0];
				pwdh_pkg::REG_DIST:   dist_q   <= cfg_data;
				pwdh_pkg::REG_TILT:   tilt_q   <= cfg_data[22:0];
				pwdh_pkg::REG_WIDTH:  width_q  <= cfg_data[15:0];
				pwdh_pkg::REG_HEIGHT: height_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// stage 1: checks and initial vector
	logic              bad_cfg;
	logic              out_range;
	logic [16:0]       row2;
	logic [16:0]       h17;
	logic              valid_s1;
	logic [1:0]        err_s1;
	logic signed [17:0] vx_s1;
	logic signed [17:0] vy_s1;
	logic [15:0]       hd_s1;
	logic              neg_h_s1;

	always_comb begin
		bad_cfg   = (focal_q == '0) || (dist_q == '0) || (tilt_q == '0) ||
		            (width_q == '0) || (height_q == '0);
		out_range = (pixel.pixel_col > width_q) || (pixel.pixel_row > height_q);
		row2      = {pixel.pixel_row, 1'b0};
		h17       = {1'b0, height_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		err_s1   <= bad_cfg ? pwdh_pkg::ST_BAD_CFG :
		            (out_range ? pwdh_pkg::ST_RANGE : pwdh_pkg::ST_OK);
		vx_s1    <= signed'({1'b0, focal_q, 1'b0});
		vy_s1    <= signed'({2'b00, width_q}) - signed'({1'b0, pixel.pixel_col, 1'b0});
		neg_h_s1 <= row2 > h17;
		hd_s1    <= (row2 > h17) ? 16'(row2 - h17) : 16'(h17 - row2);
	end

	// stage 2: normalize and take out a quarter turn
	logic [16:0]       ay1;
	logic [16:0]       mx;
	logic [4:0]        msb;
	logic [4:0]        sh;
	logic signed [VW-1:0] x0;
	logic signed [VW-1:0] y0;
	logic [AW-1:0]     t0;
	pwdh_pkg::cordic_t cw [pwdh_pkg::CORDIC_STAGES+1];
	pwdh_pkg::cordic_t c_in;

	always_comb begin
		ay1 = vy_s1[17] ? 17'(-vy_s1) : 17'(vy_s1);
		mx  = (17'(vx_s1) > ay1) ? 17'(vx_s1) : ay1;
		msb = '0;
		for (int i = 0; i < 17; i++) begin
			if (mx[i]) begin
				msb = 5'(i);
			end
		end
		sh = 5'd29 - msb;
		x0 = VW'(vx_s1) <<< sh;
		y0 = VW'(vy_s1) <<< sh;
		t0 = AW'({tilt_q, {(pwdh_pkg::ANG_FRAC - pwdh_pkg::FRAC_BITS){1'b0}}});
		c_in.valid = valid_s1;
		c_in.err   = err_s1;
		c_in.neg_h = neg_h_s1;
		c_in.hd    = hd_s1;
		if (t0 > pwdh_pkg::DEG90) begin
			c_in.x   = -y0;
			c_in.y   = x0;
			c_in.ang = signed'(t0 - pwdh_pkg::DEG90);
		end else begin
			c_in.x   = x0;
			c_in.y   = y0;
			c_in.ang = signed'(t0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw[0] <= '0;
		end else begin
			cw[0] <= c_in;
		end
	end

	genvar g;
	for (g = 0; g < pwdh_pkg::CORDIC_STAGES; g++) begin : g_cordic
		pwdh_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (5'(g)),
			.din    (cw[g]),
			.dout   (cw[g+1])
		);
	end

	// stage 3: magnitudes and products
	pwdh_pkg::cordic_t c_out;
	logic [VW-1:0]     axf;
	logic [VW-1:0]     ayf;
	logic              valid_s3;
	logic [1:0]        err_s3;
	logic              neg_h_s3;
	logic [15:0]       hd_s3;
	logic              neg_d_s3;
	logic [31:0]       ax_s3;
	logic [63:0]       sqx_s3;
	logic [63:0]       sqy_s3;
	logic [63:0]       pd_s3;
	logic [48:0]       denh_s3;

	always_comb begin
		c_out = cw[pwdh_pkg::CORDIC_STAGES];
		axf   = c_out.x[VW-1] ? VW'(-c_out.x) : VW'(c_out.x);
		ayf   = c_out.y[VW-1] ? VW'(-c_out.y) : VW'(c_out.y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= c_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		err_s3   <= c_out.err;
		neg_h_s3 <= c_out.neg_h;
		hd_s3    <= c_out.hd;
		neg_d_s3 <= c_out.x[VW-1] != c_out.y[VW-1];
		ax_s3    <= axf[31:0];
		sqx_s3   <= axf[31:0] * axf[31:0];
		sqy_s3   <= ayf[31:0] * ayf[31:0];
		pd_s3    <= dist_q * ayf[31:0];
		denh_s3  <= {focal_q, 1'b0} * axf[31:0];
	end

	// stage 4: root input and depth dividend
	pwdh_pkg::root_t rw [pwdh_pkg::SQRT_STAGES+1];
	pwdh_pkg::root_t r_in;

	always_comb begin
		r_in.valid       = valid_s3;
		r_in.v           = sqx_s3 + sqy_s3;
		r_in.res         = '0;
		r_in.side.err    = err_s3;
		r_in.side.neg_h  = neg_h_s3;
		r_in.side.hd     = hd_s3;
		r_in.side.neg_d  = neg_d_s3;
		r_in.side.zero_d = pd_s3 == '0;
		r_in.side.n_d    = NW'(pd_s3) + NW'(ax_s3 >> 1);
		r_in.side.den_d  = DW'(ax_s3);
		r_in.side.den_h  = DW'(denh_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rw[0] <= '0;
		end else begin
			rw[0] <= r_in;
		end
	end

	for (g = 0; g < pwdh_pkg::SQRT_STAGES; g++) begin : g_sqrt
		pwdh_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (5'(g)),
			.din    (rw[g]),
			.dout   (rw[g+1])
		);
	end

	// stages 5 to 7: height dividend
	pwdh_pkg::root_t r_out;
	logic            valid_s5, valid_s6, valid_s7;
	pwdh_pkg::side_t side_s5, side_s6, side_s7;
	logic [47:0]     b_s5;
	logic [55:0]     plo_s6;
	logic [55:0]     phi_s6;
	logic [79:0]     ph;
	logic [NW-1:0]   nh_s7;
	logic            zero_h_s7;

	assign r_out = rw[pwdh_pkg::SQRT_STAGES];
	assign ph    = {phi_s6, 24'b0} + 80'(plo_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s5 <= r_out.valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		side_s5   <= r_out.side;
		b_s5      <= r_out.side.hd * r_out.res[31:0];
		side_s6   <= side_s5;
		plo_s6    <= dist_q * b_s5[23:0];
		phi_s6    <= dist_q * b_s5[47:24];
		side_s7   <= side_s6;
		nh_s7     <= NW'(ph) + NW'(side_s6.den_h >> 1);
		zero_h_s7 <= ph == '0;
	end

	// stage 8: divider setup
	pwdh_pkg::quot_t dq [QW+1];
	pwdh_pkg::quot_t hq [QW+1];
	pwdh_pkg::quot_t d_in;
	pwdh_pkg::quot_t h_in;

	always_comb begin
		d_in.valid = valid_s7;
		d_in.err   = side_s7.err;
		d_in.neg   = side_s7.neg_d;
		d_in.zero  = (side_s7.den_d == '0) && side_s7.zero_d;
		d_in.ovf   = (side_s7.n_d >> QW) >= NW'(side_s7.den_d);
		d_in.n     = side_s7.n_d;
		d_in.den   = side_s7.den_d;
		d_in.r     = DW'(side_s7.n_d >> QW);
		d_in.q     = '0;
		h_in.valid = valid_s7;
		h_in.err   = side_s7.err;
		h_in.neg   = side_s7.neg_h;
		h_in.zero  = (side_s7.den_h == '0) && zero_h_s7;
		h_in.ovf   = (nh_s7 >> QW) >= NW'(side_s7.den_h);
		h_in.n     = nh_s7;
		h_in.den   = side_s7.den_h;
		h_in.r     = DW'(nh_s7 >> QW);
		h_in.q     = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dq[0] <= '0;
			hq[0] <= '0;
		end else begin
			dq[0] <= d_in;
			hq[0] <= h_in;
		end
	end

	for (g = 0; g < QW; g++) begin : g_div
		pwdh_div_cell u_depth (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (6'(g)),
			.din    (dq[g]),
			.dout   (dq[g+1])
		);
		pwdh_div_cell u_height (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (6'(g)),
			.din    (hq[g]),
			.dout   (hq[g+1])
		);
	end

	// output: rounding already in the dividend, saturate and sign
	function automatic logic [QW:0] finish(input pwdh_pkg::quot_t w);
		logic [QW-1:0] lim;
		logic [QW-1:0] q;
		logic          sat;
		lim = w.neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
		q   = w.q;
		sat = 1'b0;
		if (w.zero) begin
			q = '0;
		end else if (w.ovf || (q > lim)) begin
			sat = 1'b1;
			q   = lim;
		end
		finish = {sat, w.neg ? QW'(-q) : q};
	endfunction

	pwdh_pkg::quot_t   d_fin;
	pwdh_pkg::quot_t   h_fin;
	logic [QW:0]       d_res;
	logic [QW:0]       h_res;
	pwdh_pkg::result_t res_nxt;
	logic              done_q;
	pwdh_pkg::result_t result_q;

	always_comb begin
		d_fin = dq[QW];
		h_fin = hq[QW];
		d_res = finish(d_fin);
		h_res = finish(h_fin);
		if (d_fin.err != pwdh_pkg::ST_OK) begin
			res_nxt.height_out = '0;
			res_nxt.depth_out  = '0;
			res_nxt.status     = d_fin.err;
		end else begin
			res_nxt.height_out = signed'(h_res[QW-1:0]);
			res_nxt.depth_out  = signed'(d_res[QW-1:0]);
			res_nxt.status     = (d_res[QW] || h_res[QW]) ? pwdh_pkg::ST_SAT : pwdh_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d_fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_nxt;
	end

	assign done   = done_q;
	assign result = result_q;
endmodule
`default_nettype wire

FILE: src/pwdh_checker.sv
// pwdh_checker: port level assertions for the pixel to world block, bound to the top level
// depends on pwdh_pkg and pixel_to_world_depth_height_top
`default_nettype none
module pwdh_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input pwdh_pkg::result_t result
);
	localparam logic [47:0] POS_LIM = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] NEG_LIM = 48'h8000_0000_0000;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(pwdh_pkg::LATENCY) done)
		else $error("word result missing at fixed latency");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == pwdh_pkg::ST_BAD_CFG ||
		         result.status == pwdh_pkg::ST_RANGE)
		|-> result.height_out == '0 && result.depth_out == '0)
		else $error("error word with nonzero outputs");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == pwdh_pkg::ST_SAT
		|-> (result.height_out == POS_LIM || result.height_out == NEG_LIM ||
		     result.depth_out == POS_LIM || result.depth_out == NEG_LIM))
		else $error("saturated word without a bound value");
endmodule

bind pixel_to_world_depth_height_top pwdh_checker u_pwdh_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
`default_nettype wire
